### design/assert_macros.svh
// Assertion macros used by the matcher scan sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every rising edge outside reset.
`define MPBM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression must never be true outside reset.
`define MPBM_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MPBM_ASSERT(lbl, clk, rst_n, prop, msg)
`define MPBM_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

### design/mpbm_pkg.sv
// Package with the types and constants of the multi-pattern byte matcher.
`timescale 1ns / 1ps
package mpbm_pkg;

	localparam int NUM_STATES   = 1024;
	localparam int STATE_W      = 10;
	localparam int MAX_OUTPUTS  = 8;
	localparam int SLOT_W       = 3;
	localparam int CNT_W        = 4;
	localparam int NUM_PATTERNS = 256;
	localparam int ID_W         = 8;
	localparam int LEN_W        = 16;
	localparam int OFFSET_W     = 32;
	localparam int BYTE_W       = 8;

	localparam int TRANS_AW    = STATE_W + BYTE_W;
	localparam int IDS_AW      = STATE_W + SLOT_W;
	localparam int TRANS_DEPTH = NUM_STATES * 256;
	localparam int IDS_DEPTH   = NUM_STATES * MAX_OUTPUTS;

	localparam logic [OFFSET_W-1:0] POS_MAX = {OFFSET_W{1'b1}};

	typedef enum logic [1:0] {
		OP_SCAN     = 2'd0,
		OP_WR_TRANS = 2'd1,
		OP_WR_SLOT  = 2'd2,
		OP_WR_LEN   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TRANS,
		ST_COUNT,
		ST_LEN,
		ST_CALC
	} fsm_t;

	typedef struct packed {
		opcode_t               opcode;
		logic [BYTE_W-1:0]     data_byte;
		logic                  restart;
		logic [OFFSET_W-1:0]   start_offset;
		logic [STATE_W-1:0]    node;
		logic [STATE_W-1:0]    next_node;
		logic [SLOT_W-1:0]     slot;
		logic [ID_W-1:0]       pattern_id;
		logic [CNT_W-1:0]      out_count;
		logic [LEN_W-1:0]      pattern_length;
	} in_item_t;

	typedef struct packed {
		logic                  trans_we;
		logic [TRANS_AW-1:0]   trans_waddr;
		logic [STATE_W-1:0]    trans_wdata;
		logic                  trans_re;
		logic [TRANS_AW-1:0]   trans_raddr;
		logic                  ids_we;
		logic [IDS_AW-1:0]     ids_waddr;
		logic [ID_W-1:0]       ids_wdata;
		logic                  ids_re;
		logic [IDS_AW-1:0]     ids_raddr;
		logic                  cnt_we;
		logic [STATE_W-1:0]    cnt_waddr;
		logic [CNT_W-1:0]      cnt_wdata;
		logic                  cnt_re;
		logic [STATE_W-1:0]    cnt_raddr;
		logic                  len_we;
		logic [ID_W-1:0]       len_waddr;
		logic [LEN_W-1:0]      len_wdata;
		logic                  len_re;
		logic [ID_W-1:0]       len_raddr;
	} tbl_req_t;

	typedef struct packed {
		logic                  clear_busy;
		logic [STATE_W-1:0]    trans;
		logic [ID_W-1:0]       id;
		logic [CNT_W-1:0]      cnt;
		logic [LEN_W-1:0]      len;
	} tbl_rsp_t;

	typedef struct packed {
		logic                  valid;
		logic [OFFSET_W-1:0]   start;
		logic [ID_W-1:0]       id;
		logic                  last;
	} emit_t;

endpackage

### design/mpbm_tables.sv
// Automaton tables: transition, output id, output count and pattern length memories.
`timescale 1ns / 1ps
module mpbm_tables import mpbm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  tbl_req_t req,
	output tbl_rsp_t rsp
);

	logic [STATE_W-1:0] trans_mem [0:TRANS_DEPTH-1];
	logic [ID_W-1:0]    ids_mem   [0:IDS_DEPTH-1];
	logic [CNT_W-1:0]   cnt_mem   [0:NUM_STATES-1];
	logic [LEN_W-1:0]   len_mem   [0:NUM_PATTERNS-1];

	logic [STATE_W-1:0] trans_rd_q;
	logic [ID_W-1:0]    ids_rd_q;
	logic [CNT_W-1:0]   cnt_rd_q;
	logic [LEN_W-1:0]   len_rd_q;

	logic               clear_busy_q;
	logic [STATE_W-1:0] clear_idx_q;

	logic               cnt_we;
	logic [STATE_W-1:0] cnt_waddr;
	logic [CNT_W-1:0]   cnt_wdata;

	// The count table must read as zero after reset, so it is swept once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_busy_q <= 1'b1;
			clear_idx_q  <= '0;
		end else if (clear_busy_q) begin
			clear_idx_q <= clear_idx_q + 1'b1;
			if (clear_idx_q == STATE_W'(NUM_STATES - 1)) begin
				clear_busy_q <= 1'b0;
			end
		end
	end

	assign cnt_we    = clear_busy_q | req.cnt_we;
	assign cnt_waddr = clear_busy_q ? clear_idx_q : req.cnt_waddr;
	assign cnt_wdata = clear_busy_q ? '0 : req.cnt_wdata;

	always_ff @(posedge clk) begin
		if (req.trans_we) begin
			trans_mem[req.trans_waddr] <= req.trans_wdata;
		end
		if (req.trans_re) begin
			trans_rd_q <= trans_mem[req.trans_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.ids_we) begin
			ids_mem[req.ids_waddr] <= req.ids_wdata;
		end
		if (req.ids_re) begin
			ids_rd_q <= ids_mem[req.ids_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		if (req.cnt_re) begin
			cnt_rd_q <= cnt_mem[req.cnt_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.len_we) begin
			len_mem[req.len_waddr] <= req.len_wdata;
		end
		if (req.len_re) begin
			len_rd_q <= len_mem[req.len_raddr];
		end
	end

	assign rsp.clear_busy = clear_busy_q;
	assign rsp.trans      = trans_rd_q;
	assign rsp.id         = ids_rd_q;
	assign rsp.cnt        = cnt_rd_q;
	assign rsp.len        = len_rd_q;

endmodule

### design/mpbm_scan.sv
// Scan sequencer: steps the automaton, walks output lists and forms match results.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mpbm_scan import mpbm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t item,
	input  logic     table_ready,
	input  logic     out_free,
	output emit_t    emit,
	output tbl_req_t req,
	input  tbl_rsp_t rsp
);

	fsm_t                fsm_q, fsm_d;
	logic [STATE_W-1:0]  node_q, node_d;
	logic [OFFSET_W-1:0] pos_q, pos_d;
	logic [SLOT_W-1:0]   k_q, k_d;
	logic [ID_W-1:0]     id_q, id_d;

	logic                can_accept;
	logic                accept;
	logic                last_match;
	logic [OFFSET_W-1:0] pos_inc;
	logic [LEN_W-1:0]    len_m1;
	logic [OFFSET_W-1:0] match_start;
	logic [STATE_W-1:0]  scan_node;

	assign pos_inc    = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
	assign len_m1     = rsp.len - 1'b1;
	assign last_match = ({1'b0, k_q} + 1'b1) == rsp.cnt;
	assign scan_node  = item.restart ? '0 : node_q;

	// Start offset is position + 1 - length, clamped at zero; a zero length
	// gives position + 1, held at the top of the offset range.
	always_comb begin
		if (rsp.len == '0) begin
			match_start = pos_inc;
		end else if (OFFSET_W'(len_m1) > pos_q) begin
			match_start = '0;
		end else begin
			match_start = pos_q - OFFSET_W'(len_m1);
		end
	end

	// A new item is taken, once the count table clear is over, when idle, or when the
	// state just reached has an empty output list.
	assign can_accept = !rsp.clear_busy &&
		(fsm_q == ST_IDLE || (fsm_q == ST_COUNT && rsp.cnt == '0));
	assign in_ready   = can_accept;
	assign accept     = can_accept && in_valid;

	always_comb begin
		fsm_d  = fsm_q;
		node_d = node_q;
		pos_d  = pos_q;
		k_d    = k_q;
		id_d   = id_q;
		req    = '0;
		emit   = '0;

		case (fsm_q)
			ST_IDLE: begin
				fsm_d = ST_IDLE;
			end
			ST_TRANS: begin
				node_d        = rsp.trans;
				req.cnt_re    = 1'b1;
				req.cnt_raddr = rsp.trans;
				req.ids_re    = 1'b1;
				req.ids_raddr = {rsp.trans, {SLOT_W{1'b0}}};
				k_d           = '0;
				fsm_d         = ST_COUNT;
			end
			ST_COUNT: begin
				if (rsp.cnt == '0) begin
					pos_d = pos_inc;
					fsm_d = ST_IDLE;
				end else begin
					req.len_re    = 1'b1;
					req.len_raddr = rsp.id;
					id_d          = rsp.id;
					fsm_d         = ST_CALC;
				end
			end
			ST_LEN: begin
				req.len_re    = 1'b1;
				req.len_raddr = rsp.id;
				id_d          = rsp.id;
				fsm_d         = ST_CALC;
			end
			ST_CALC: begin
				if (out_free) begin
					emit.valid = 1'b1;
					emit.start = match_start;
					emit.id    = id_q;
					emit.last  = last_match;
					if (last_match) begin
						pos_d = pos_inc;
						fsm_d = ST_IDLE;
					end else begin
						k_d           = k_q + 1'b1;
						req.ids_re    = 1'b1;
						req.ids_raddr = {node_q, k_q + 1'b1};
						fsm_d         = ST_LEN;
					end
				end
			end
			default: begin
				fsm_d = ST_IDLE;
			end
		endcase

		if (accept) begin
			case (item.opcode)
				OP_WR_TRANS: begin
					req.trans_we    = 1'b1;
					req.trans_waddr = {item.node, item.data_byte};
					req.trans_wdata = item.next_node;
				end
				OP_WR_SLOT: begin
					req.ids_we    = 1'b1;
					req.ids_waddr = {item.node, item.slot};
					req.ids_wdata = item.pattern_id;
					req.cnt_we    = 1'b1;
					req.cnt_waddr = item.node;
					req.cnt_wdata = (item.out_count > CNT_W'(MAX_OUTPUTS)) ?
						CNT_W'(MAX_OUTPUTS) : item.out_count;
				end
				OP_WR_LEN: begin
					req.len_we    = 1'b1;
					req.len_waddr = item.pattern_id;
					req.len_wdata = item.pattern_length;
				end
				OP_SCAN: begin
					if (item.restart) begin
						node_d = '0;
						pos_d  = item.start_offset;
					end
					if (table_ready) begin
						req.trans_re    = 1'b1;
						req.trans_raddr = {scan_node, item.data_byte};
						fsm_d           = ST_TRANS;
					end
				end
				default: begin
					fsm_d = ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q  <= ST_IDLE;
			node_q <= '0;
			pos_q  <= '0;
			k_q    <= '0;
		end else begin
			fsm_q  <= fsm_d;
			node_q <= node_d;
			pos_q  <= pos_d;
			k_q    <= k_d;
		end
	end

	always_ff @(posedge clk) begin
		id_q <= id_d;
	end

	`MPBM_ASSERT_NEVER(a_no_accept_in_clear, clk, arst_n, in_ready && rsp.clear_busy,
		"item taken during count table clear")
	`MPBM_ASSERT(a_slot_in_list, clk, arst_n, (fsm_q == ST_CALC) |-> ({1'b0, k_q} < rsp.cnt),
		"output slot beyond list length")
	`MPBM_ASSERT(a_count_bounded, clk, arst_n,
		(fsm_q == ST_COUNT) |-> (rsp.cnt <= CNT_W'(MAX_OUTPUTS)), "output count above maximum")
	`MPBM_ASSERT(a_last_ends_item, clk, arst_n, (emit.valid && emit.last) |=> (fsm_q == ST_IDLE),
		"sequencer busy after final match")

endmodule

### design/multi_pattern_byte_matcher_top.sv
// Top level of the multi-pattern byte matcher: ports, register, result stage.
`timescale 1ns / 1ps
// Table writes complete as they are accepted and can follow back to back. A scanned byte
// with no match passes the transition read, which feeds the output count read. Each match
// reads the output id, then the pattern length, and waits while the result register
// is full; a byte's first result passes the transition, count and id, and length reads
// and the result register. After reset, a clearing pass zeroes the output counts; no
// item is accepted meanwhile. Reset puts the automaton at the root and position at zero.
module multi_pattern_byte_matcher_top import mpbm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Slave side: input items.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// From bit 0: data_byte[7:0], restart[8], start_offset[40:9], node[50:41],
	// next_node[60:51], slot[63:61], pattern_id[71:64], out_count[75:72],
	// pattern_length[91:76], zero fill [95:92].
	input  logic [95:0] s_axis_tdata,
	// From bit 0: opcode[1:0].
	input  logic [1:0]  s_axis_tuser,
	// Master side: result items.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// From bit 0: match_start[31:0], match_id[39:32].
	output logic [39:0] m_axis_tdata,
	output logic        m_axis_tlast,
	// Configuration: table_ready.
	input  logic        cfg_we,
	input  logic        cfg_wdata
);

	in_item_t            item;
	tbl_req_t            req;
	tbl_rsp_t            rsp;
	emit_t               emit;
	logic                out_free;

	logic                table_ready_q;
	logic                out_valid_q;
	logic [OFFSET_W-1:0] out_start_q;
	logic [ID_W-1:0]     out_id_q;
	logic                out_last_q;

	// Unpack the slave payload into the item fields.
	assign item.opcode         = opcode_t'(s_axis_tuser);
	assign item.data_byte      = s_axis_tdata[7:0];
	assign item.restart        = s_axis_tdata[8];
	assign item.start_offset   = s_axis_tdata[40:9];
	assign item.node           = s_axis_tdata[50:41];
	assign item.next_node      = s_axis_tdata[60:51];
	assign item.slot           = s_axis_tdata[63:61];
	assign item.pattern_id     = s_axis_tdata[71:64];
	assign item.out_count      = s_axis_tdata[75:72];
	assign item.pattern_length = s_axis_tdata[91:76];

	// The table-ready register is to be written only while the block is idle; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_ready_q <= 1'b0;
		end else if (cfg_we) begin
			table_ready_q <= cfg_wdata;
		end
	end

	mpbm_tables u_tables (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	mpbm_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.item        (item),
		.table_ready (table_ready_q),
		.out_free    (out_free),
		.emit        (emit),
		.req         (req),
		.rsp         (rsp)
	);

	// Result register: the sequencer hands a match over only when this stage
	// is empty or being drained in the same cycle, so no result is dropped.
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit.valid) begin
			out_start_q <= emit.start;
			out_id_q    <= emit.id;
			out_last_q  <= emit.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_id_q, out_start_q};
	assign m_axis_tlast  = out_last_q;

endmodule

### tb/multi_pattern_byte_matcher_top_tb.sv
// Self-checking testbench of the multi-pattern byte matcher: table loading, scans, matches.
`timescale 1ns / 1ps
module multi_pattern_byte_matcher_top_tb;
	import mpbm_pkg::*;

	// States that scans may visit. Transitions from these states only ever lead back
	// into the set, so the automaton never walks onto a table entry nobody wrote.
	localparam int LIVE_N      = 5;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYC  = 24;

	typedef struct packed {
		logic [OFFSET_W-1:0] start;
		logic [ID_W-1:0]     id;
		logic                last;
	} hit_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = OP_SCAN;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;

	multi_pattern_byte_matcher_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always #10 clk = ~clk;

	// Shadow of the automaton, advanced as each item is accepted by the block.
	bit [STATE_W-1:0]  auto_trans [0:TRANS_DEPTH-1];
	bit [ID_W-1:0]     auto_ids   [0:IDS_DEPTH-1];
	bit [CNT_W-1:0]    auto_cnt   [0:NUM_STATES-1];
	bit [LEN_W-1:0]    auto_len   [0:NUM_PATTERNS-1];
	bit [STATE_W-1:0]  auto_state = '0;
	bit [OFFSET_W-1:0] auto_pos   = '0;
	bit                auto_ready = 1'b0;

	hit_t     match_fifo [$];
	in_item_t item_backlog [$];
	int       errors = 0;

	// Planning view used while the stimulus is built: which transitions, output slots
	// and pattern lengths have been written, and where the automaton will stand.
	int       route_to  [0:LIVE_N*256-1];
	bit       route_set [0:LIVE_N*256-1];
	bit [7:0] route_sym [0:LIVE_N*256-1];
	int       route_cnt [0:LIVE_N-1];
	bit       slot_set  [0:LIVE_N*MAX_OUTPUTS-1];
	bit [7:0] len_ids [$];
	bit       len_known [0:NUM_PATTERNS-1];
	int       plan_at = 0;
	bit       plan_ready = 1'b0;

	function automatic logic [STATE_W-1:0] live_node(input int li);
		case (li)
			0:       return 10'd0;
			1:       return 10'd1023;
			2:       return 10'd341;
			3:       return 10'd682;
			default: return 10'd900;
		endcase
	endfunction

	function automatic bit is_live(input logic [STATE_W-1:0] n);
		for (int i = 0; i < LIVE_N; i++)
			if (live_node(i) == n)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic [95:0] pack_item(input in_item_t it);
		return {4'b0, it.pattern_length, it.out_count, it.pattern_id, it.slot,
			it.next_node, it.node, it.start_offset, it.restart, it.data_byte};
	endfunction

	// Start offset of a match ending at pos; a zero length points one past pos and
	// saturates, a length reaching back beyond offset zero clamps to zero.
	function automatic logic [OFFSET_W-1:0] match_origin(input logic [OFFSET_W-1:0] pos,
			input logic [LEN_W-1:0] len);
		if (len == '0)
			return (pos == POS_MAX) ? POS_MAX : pos + 1'b1;
		if (OFFSET_W'(len) - 32'd1 > pos)
			return '0;
		return pos - (OFFSET_W'(len) - 32'd1);
	endfunction

	// Applies one accepted item to the shadow automaton and queues the matches it yields.
	task automatic scan_automaton(input in_item_t it);
		hit_t        h;
		int          n;
		bit [2:0]    k3;
		bit [ID_W-1:0] id;
		case (it.opcode)
			OP_WR_TRANS: auto_trans[{it.node, it.data_byte}] = it.next_node;
			OP_WR_SLOT: begin
				auto_ids[{it.node, it.slot}] = it.pattern_id;
				auto_cnt[it.node] = (it.out_count > MAX_OUTPUTS) ? CNT_W'(MAX_OUTPUTS)
					: it.out_count;
			end
			OP_WR_LEN: auto_len[it.pattern_id] = it.pattern_length;
			default: begin
				if (it.restart) begin
					auto_state = '0;
					auto_pos = it.start_offset;
				end
				if (auto_ready) begin
					auto_state = auto_trans[{auto_state, it.data_byte}];
					n = auto_cnt[auto_state];
					for (int k = 0; k < n; k++) begin
						k3 = 3'(k);
						id = auto_ids[{auto_state, k3}];
						h.start = match_origin(auto_pos, auto_len[id]);
						h.id = id;
						h.last = (k == n - 1);
						match_fifo.insert(match_fifo.size(), h);
					end
					if (auto_pos != POS_MAX)
						auto_pos = auto_pos + 1'b1;
				end
			end
		endcase
	endtask

	// Every field starts out random, so the fields an opcode ignores still toggle.
	function automatic in_item_t noise_item(input opcode_t op);
		in_item_t    it;
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		it = raw[93:0];
		it.opcode = op;
		return it;
	endfunction

	task automatic add_route(input int li, input bit [7:0] sym, input int lj);
		in_item_t it;
		it = noise_item(OP_WR_TRANS);
		it.node = live_node(li);
		it.data_byte = sym;
		it.next_node = live_node(lj);
		if (!route_set[li*256 + sym]) begin
			route_set[li*256 + sym] = 1'b1;
			route_sym[li*256 + route_cnt[li]] = sym;
			route_cnt[li]++;
		end
		route_to[li*256 + sym] = lj;
		item_backlog.insert(item_backlog.size(), it);
	endtask

	task automatic add_length(input bit [7:0] id, input bit [15:0] len);
		in_item_t it;
		it = noise_item(OP_WR_LEN);
		it.pattern_id = id;
		it.pattern_length = len;
		if (!len_known[id]) begin
			len_known[id] = 1'b1;
			len_ids.insert(len_ids.size(), id);
		end
		item_backlog.insert(item_backlog.size(), it);
	endtask

	task automatic add_slot(input int li, input int s, input bit [7:0] id,
			input bit [3:0] cnt);
		in_item_t it;
		it = noise_item(OP_WR_SLOT);
		it.node = live_node(li);
		it.slot = SLOT_W'(s);
		it.pattern_id = id;
		it.out_count = cnt;
		slot_set[li*MAX_OUTPUTS + s] = 1'b1;
		item_backlog.insert(item_backlog.size(), it);
	endtask

	task automatic add_scan(input bit rst, input bit [31:0] off, input bit [7:0] sym);
		in_item_t it;
		it = noise_item(OP_SCAN);
		it.restart = rst;
		it.start_offset = off;
		it.data_byte = sym;
		if (rst)
			plan_at = 0;
		if (plan_ready)
			plan_at = route_to[plan_at*256 + sym];
		item_backlog.insert(item_backlog.size(), it);
	endtask

	// Mostly well-formed scans along written transitions, mixed with table updates
	// that keep every reachable output list fully written, and writes to unused states.
	task automatic random_phase(input int count);
		int        r, li, lj, s, maxc, at;
		bit        rst;
		bit [31:0] off;
		bit [7:0]  sym;
		bit [3:0]  c;
		in_item_t  it;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 62) begin
				rst = ($urandom_range(0, 9) == 0);
				case ($urandom_range(0, 2))
					0:       off = $urandom_range(0, 48);
					1:       off = POS_MAX - $urandom_range(0, 24);
					default: off = $urandom;
				endcase
				at = rst ? 0 : plan_at;
				if (plan_ready)
					sym = route_sym[at*256 + $urandom_range(0, route_cnt[at] - 1)];
				else
					sym = 8'($urandom_range(0, 255));
				add_scan(rst, off, sym);
			end else if (r < 74) begin
				li = $urandom_range(0, LIVE_N - 1);
				lj = $urandom_range(0, LIVE_N - 1);
				if ($urandom_range(0, 1))
					sym = 8'($urandom_range(0, 255));
				else
					sym = route_sym[li*256 + $urandom_range(0, route_cnt[li] - 1)];
				add_route(li, sym, lj);
			end else if (r < 84) begin
				li = $urandom_range(0, LIVE_N - 1);
				s = $urandom_range(0, MAX_OUTPUTS - 1);
				// The count may only cover slots that already hold an id.
				maxc = 0;
				while (maxc < MAX_OUTPUTS && (slot_set[li*MAX_OUTPUTS + maxc] || maxc == s))
					maxc++;
				c = (maxc == MAX_OUTPUTS) ? 4'($urandom_range(0, 15))
					: 4'($urandom_range(0, maxc));
				add_slot(li, s, len_ids[$urandom_range(0, len_ids.size() - 1)], c);
			end else if (r < 92) begin
				add_length(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0) ?
					16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 64)));
			end else begin
				it = noise_item($urandom_range(0, 1) ? OP_WR_TRANS : OP_WR_SLOT);
				while (is_live(it.node))
					it.node = STATE_W'($urandom_range(0, NUM_STATES - 1));
				item_backlog.insert(item_backlog.size(), it);
			end
		end
	endtask

	// Waits for the block to go quiet: every item taken, every match seen, then a
	// margin longer than the block's own latency.
	task automatic settle();
		while (item_backlog.size() != 0 || s_axis_tvalid || match_fifo.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_ready(input bit v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		auto_ready = v;
		plan_ready = v;
		@(negedge clk);
	endtask

	// Sender: presents items in bursts of random length separated by random gaps;
	// now and then a long burst with no gap at all.
	int       burst_left = 0;
	int       gap_left = 0;
	in_item_t drv_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				scan_automaton(drv_item);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (item_backlog.size() != 0) begin
					drv_item = item_backlog.pop_front();
					s_axis_tdata <= pack_item(drv_item);
					s_axis_tuser <= drv_item.opcode;
					s_axis_tvalid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else if ($urandom_range(0, 3) == 0) begin
						burst_left = $urandom_range(20, 40);
						gap_left = 0;
					end else begin
						burst_left = $urandom_range(0, 7);
						gap_left = $urandom_range(0, 5);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: cycles through always ready, coin-toss, a fixed stall pattern and
	// rarely ready, a quarter of the time each.
	bit [8:0] stall_tick = '0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			stall_tick <= stall_tick + 1'b1;
			case (stall_tick[8:7])
				2'd0:    m_axis_tready <= 1'b1;
				2'd1:    m_axis_tready <= 1'($urandom_range(0, 1));
				2'd2:    m_axis_tready <= (stall_tick[3:0] >= 4'd3);
				default: m_axis_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Match checker: each accepted result against the oldest outstanding match.
	hit_t seen;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (match_fifo.size() == 0) begin
				$display("%0t: unexpected match: start %0h id %0h last %0b", $time,
					m_axis_tdata[31:0], m_axis_tdata[39:32], m_axis_tlast);
				errors++;
			end else begin
				seen = match_fifo.pop_front();
				if (m_axis_tdata[31:0] !== seen.start) begin
					$display("%0t: match_start expected %0h actual %0h", $time,
						seen.start, m_axis_tdata[31:0]);
					errors++;
				end
				if (m_axis_tdata[39:32] !== seen.id) begin
					$display("%0t: match_id expected %0h actual %0h", $time,
						seen.id, m_axis_tdata[39:32]);
					errors++;
				end
				if (m_axis_tlast !== seen.last) begin
					$display("%0t: last expected %0b actual %0b", $time,
						seen.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	// Watchdog: ends the run if neither side moves an item for too long. The limit
	// covers the clearing pass after reset and the quiet spells between phases.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		bit [7:0] list_ids [0:7];
		list_ids = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd128, 8'd1, 8'd255, 8'd0};
		for (int i = 0; i < LIVE_N; i++)
			route_cnt[i] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		write_ready(1'b0);

		// Tables not ready: scans only apply their restart and yield nothing.
		add_scan(1'b1, 32'hFFFF_FFFF, 8'h3C);
		add_scan(1'b0, 32'h0, 8'hC3);
		// Pattern lengths at the extremes.
		add_length(8'd0, 16'd0);
		add_length(8'd255, 16'hFFFF);
		add_length(8'd1, 16'd1);
		add_length(8'd128, 16'd3);
		// A ring through the states: root, 1023, 682, 900 and back, and 341 beside it.
		add_route(0, 8'hFF, 1);
		add_route(0, 8'h00, 2);
		add_route(1, 8'h55, 3);
		add_route(2, 8'hAA, 0);
		add_route(3, 8'h01, 4);
		add_route(4, 8'h80, 0);
		// State 1023 reports a full list; the last write's count saturates.
		for (int s = 0; s < MAX_OUTPUTS; s++)
			add_slot(1, s, list_ids[s], (s == MAX_OUTPUTS - 1) ? 4'd15 : 4'(s + 1));
		add_slot(2, 0, 8'd128, 4'd1);
		add_slot(3, 0, 8'd255, 4'd0);
		settle();
		write_ready(1'b1);

		// Full match list at offset zero, then states with an empty list.
		add_scan(1'b1, 32'h0, 8'hFF);
		add_scan(1'b0, 32'h0, 8'h55);
		add_scan(1'b0, 32'h0, 8'h01);
		add_scan(1'b0, 32'h0, 8'h80);
		// Restart just below the top: the position saturates, and a zero length
		// match at the largest position stays there.
		add_scan(1'b1, 32'hFFFF_FFFE, 8'h00);
		add_scan(1'b0, 32'h0, 8'hAA);
		add_scan(1'b0, 32'h0, 8'hFF);
		random_phase(110);
		settle();

		write_ready(1'b0);
		random_phase(20);
		settle();

		write_ready(1'b1);
		random_phase(91);
		settle();

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
